### hdl/sfd_pkg.sv
package sfd_pkg;

    // Largest payload that a frame may carry; longer frames are dropped.
    localparam int MAX_PAYLOAD = 32;

    localparam logic [7:0] START_BYTE = 8'hFE;

    // Bytes that precede the payload in a frame: start, two function, two length.
    localparam int HDR_BYTES = 5;

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int IDX_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int SEQ_W  = $clog2(MAX_PAYLOAD + HDR_BYTES + 2);

    // Positions of the header bytes in an echoed frame.
    localparam logic [SEQ_W-1:0] SEQ_START   = SEQ_W'(0);
    localparam logic [SEQ_W-1:0] SEQ_FUNC_HI = SEQ_W'(1);
    localparam logic [SEQ_W-1:0] SEQ_FUNC_LO = SEQ_W'(2);
    localparam logic [SEQ_W-1:0] SEQ_LEN_HI  = SEQ_W'(3);
    localparam logic [SEQ_W-1:0] SEQ_LEN_LO  = SEQ_W'(4);

    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_FUNC_HI = 3'd1,
        PH_FUNC_LO = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_LEN_LO  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHECK   = 3'd6
    } parse_phase_t;

    typedef enum logic [1:0] {
        ECHO_IDLE  = 2'd0,
        ECHO_FETCH = 2'd1,
        ECHO_LOAD  = 2'd2
    } echo_state_t;

    // Handed from the parser to the echo sequencer.
    typedef struct packed {
        logic        start;
        logic [15:0] func;
        logic [15:0] len;
        logic [7:0]  csum;
    } frame_info_t;

endpackage

### hdl/sfd_ram.sv
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/sfd_parser.sv
module sfd_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_en,
    input  logic [7:0]                 rx_byte,
    output logic                       wr_en,
    output logic [sfd_pkg::ADDR_W-1:0] wr_addr,
    output logic [7:0]                 wr_data,
    output sfd_pkg::frame_info_t       info
);

    import sfd_pkg::*;

    parse_phase_t     phase_reg, phase_next;
    logic [15:0]      func_reg, func_next;
    logic [15:0]      len_reg, len_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       csum_reg, csum_next;
    logic [IDX_W-1:0] idx_inc;
    logic             match;
    logic             frame_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            func_reg  <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            csum_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            func_reg  <= func_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            csum_reg  <= csum_next;
        end
    end

    assign idx_inc = idx_reg + IDX_W'(1);
    assign match   = (rx_byte == csum_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        func_next   = func_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        csum_next   = csum_reg;
        wr_en       = 1'b0;
        frame_start = 1'b0;
        if (byte_en)
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (rx_byte == START_BYTE)
                    begin
                        csum_next  = START_BYTE;
                        phase_next = PH_FUNC_HI;
                    end
                end
                PH_FUNC_HI:
                begin
                    func_next  = {rx_byte, 8'h00};
                    csum_next  = csum_reg ^ rx_byte;
                    phase_next = PH_FUNC_LO;
                end
                PH_FUNC_LO:
                begin
                    func_next  = {func_reg[15:8], rx_byte};
                    csum_next  = csum_reg ^ rx_byte;
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next   = {rx_byte, 8'h00};
                    csum_next  = csum_reg ^ rx_byte;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next  = {len_reg[15:8], rx_byte};
                    csum_next = csum_reg ^ rx_byte;
                    idx_next  = '0;
                    if (len_next > 16'(MAX_PAYLOAD))
                    begin
                        phase_next = PH_WAIT;
                    end
                    else if (len_next == 16'd0)
                    begin
                        phase_next = PH_CHECK;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    wr_en     = 1'b1;
                    csum_next = csum_reg ^ rx_byte;
                    idx_next  = idx_inc;
                    // The length was bounded at the header, so this also stops at the store end.
                    if (16'(idx_inc) >= len_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    frame_start = match;
                    phase_next  = PH_WAIT;
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    assign wr_addr = idx_reg[ADDR_W-1:0];
    assign wr_data = rx_byte;
    assign info    = '{start: frame_start, func: func_reg, len: len_reg, csum: csum_reg};

endmodule

### hdl/sfd_echo.sv
module sfd_echo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sfd_pkg::frame_info_t       info,
    output logic                       busy,
    output logic                       rd_en,
    output logic [sfd_pkg::ADDR_W-1:0] rd_addr,
    input  logic [7:0]                 rd_data,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,
    output logic                       m_tlast
);

    import sfd_pkg::*;

    echo_state_t      state_reg, state_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;
    logic [SEQ_W-1:0] last_seq;
    logic             in_payload;
    logic             load;
    logic             is_last;
    logic [7:0]       sel_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ECHO_IDLE;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // A valid frame has at most MAX_PAYLOAD bytes, so the low bits carry the length.
    assign last_seq   = info.len[SEQ_W-1:0] + SEQ_W'(HDR_BYTES);
    assign in_payload = (seq_reg >= SEQ_W'(HDR_BYTES)) && (seq_reg < last_seq);
    assign is_last    = (seq_reg == last_seq);
    assign rd_addr    = ADDR_W'(seq_reg - SEQ_W'(HDR_BYTES));

    always_comb
    begin
        case (seq_reg)
            SEQ_START:   sel_byte = START_BYTE;
            SEQ_FUNC_HI: sel_byte = info.func[15:8];
            SEQ_FUNC_LO: sel_byte = info.func[7:0];
            SEQ_LEN_HI:  sel_byte = info.len[15:8];
            SEQ_LEN_LO:  sel_byte = info.len[7:0];
            default:     sel_byte = is_last ? info.csum : rd_data;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        seq_next       = seq_reg;
        rd_en          = 1'b0;
        load           = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ECHO_IDLE:
            begin
                if (info.start)
                begin
                    seq_next   = '0;
                    state_next = ECHO_FETCH;
                end
            end
            ECHO_FETCH:
            begin
                rd_en      = in_payload;
                state_next = ECHO_LOAD;
            end
            ECHO_LOAD:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load           = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = sel_byte;
                    out_last_next  = is_last;
                    if (is_last)
                    begin
                        state_next = ECHO_IDLE;
                    end
                    else
                    begin
                        seq_next   = seq_reg + SEQ_W'(1);
                        state_next = ECHO_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ECHO_IDLE;
            end
        endcase
    end

    assign busy     = (state_reg != ECHO_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        info.start |-> (state_reg == ECHO_IDLE))
        else $error("frame start while an echo is running");

    a_seq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (seq_reg <= last_seq))
        else $error("echo position ran past the checksum byte");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (load && is_last) |=> (state_reg == ECHO_IDLE) && m_tvalid && m_tlast)
        else $error("checksum byte did not end the echo");

    a_no_rd_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (state_reg == ECHO_FETCH) && !is_last)
        else $error("store read outside the payload");
`endif

endmodule

### hdl/serial_frame_decoder_echo.sv
// Serial frame decoder with echo.
// The slave channel (s_tvalid, s_tready, s_tdata) takes one received serial
// byte per word. The decoder hunts for the start byte 0xFE, then reads a
// 16-bit function code and a 16-bit length (both MSB first), the payload and
// an XOR checksum. Payload bytes go into a 32-entry synchronous RAM.
// When the checksum matches, the master channel (m_tvalid, m_tready, m_tdata,
// m_tlast) sends the whole frame back, 6 + length words, with m_tlast on the
// checksum word. A bad checksum, or a length above 32, drops the frame silently.
// Throughput: while parsing, one byte is taken every cycle. Once the checksum
// word is taken, the sequencer steps from idle to fetch to load, and the load
// puts the first echo word into the output register. Each later word takes a
// fetch and then a load over the single RAM read port, and s_tready stays low
// for the whole echo. The input reopens as soon as the checksum word sits in
// the output register, even if the receiver has not taken it yet.
// When the receiver holds m_tready low, the output register keeps its word
// and the sequencer waits. Reset (rst_n low) returns the decoder to hunting
// for a start byte and empties the output register; the RAM is not cleared.
module serial_frame_decoder_echo (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] tx_byte
    output logic       m_tlast
);

    import sfd_pkg::*;

    frame_info_t       info;
    logic              busy;
    logic              byte_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // Input is held off for the length of an echo burst.
    assign s_tready = !busy;
    assign byte_en  = s_tvalid && s_tready;

    sfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_en),
        .rx_byte (s_tdata),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .info    (info)
    );

    sfd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sfd_echo u_echo (
        .clk      (clk),
        .rst_n    (rst_n),
        .info     (info),
        .busy     (busy),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
